/* rtl/sst_pkg.sv */
package sst_pkg;

  // Table geometry. Every width below is derived from the slot count.
  localparam int SLOT_COUNT = 64;
  localparam int IDX_W      = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int CNT_W      = $clog2(SLOT_COUNT + 1);

  // Fixed field widths.
  localparam int CMD_W   = 2;
  localparam int OWNER_W = 16;
  localparam int PAGE_W  = 20;
  localparam int PERM_W  = 12;
  localparam int STAT_W  = 2;
  localparam int OIDX_W  = 6;

  typedef enum logic [CMD_W-1:0] {
    CMD_ALLOC   = 2'd0,
    CMD_TAKE    = 2'd1,
    CMD_RELEASE = 2'd2
  } sst_cmd_t;

  typedef enum logic [STAT_W-1:0] {
    ST_DONE    = 2'd0,
    ST_FULL    = 2'd1,
    ST_MISSING = 2'd2
  } sst_status_t;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_SCAN = 1'b1
  } sst_state_t;

  // Controller to datapath.
  typedef struct packed {
    logic load;    // capture a new request and restart the scan
    logic step;    // scanning: issue the next read, act on the slot under test
    logic finish;  // register the result this cycle
  } sst_ctl_t;

  // Datapath to controller.
  typedef struct packed {
    logic found;   // allocate or take has its slot
    logic last;    // the slot under test is the final one
  } sst_sts_t;

  // One stored slot, apart from its used mark.
  typedef struct packed {
    logic [OWNER_W-1:0] owner;
    logic [PAGE_W-1:0]  page;
    logic [PERM_W-1:0]  perm;
  } sst_entry_t;

  // Slot number to the six-bit result field (low bits kept, zero-extended).
  function automatic logic [OIDX_W-1:0] to_out_idx(input logic [IDX_W-1:0] idx);
    logic [31:0] ext;
    ext = 32'(idx);
    return ext[OIDX_W-1:0];
  endfunction

endpackage

/* rtl/sst_ctrl.sv */
module sst_ctrl
  import sst_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  input  sst_sts_t   sts,
  output logic       busy,
  output sst_ctl_t   ctl
);

  sst_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    ctl.load   = 1'b0;
    ctl.step   = 1'b0;
    ctl.finish = 1'b0;
    busy       = 1'b1;
    case (state_r)
      S_IDLE: begin
        busy = 1'b0;
        if (start) begin
          ctl.load  = 1'b1;
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        ctl.step = 1'b1;
        if (sts.found || sts.last) begin
          ctl.finish = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // A request always leads into the scan.
  a_load_scans: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.load |=> (state_r == S_SCAN))
    else $error("request accepted but no scan started");

endmodule

/* rtl/sst_data.sv */
module sst_data
  import sst_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  sst_ctl_t           ctl,
  input  logic [CMD_W-1:0]   in_command,
  input  logic [OWNER_W-1:0] in_owner_id,
  input  logic [PAGE_W-1:0]  in_page_number,
  input  logic [PERM_W-1:0]  in_permission_bits,
  output sst_sts_t           sts,
  output logic               out_strobe,
  output logic [STAT_W-1:0]  out_status,
  output logic [OIDX_W-1:0]  out_slot_index,
  output logic [PERM_W-1:0]  out_saved_permissions
);

  // Request registers.
  logic [CMD_W-1:0]   cmd_r;
  logic [OWNER_W-1:0] owner_r;
  logic [PAGE_W-1:0]  page_r;
  logic [PERM_W-1:0]  perm_r;

  // Scan pipeline: read issued at addr_r, slot tested at chk_idx_r.
  logic [CNT_W-1:0]   addr_r, addr_nxt;
  logic [IDX_W-1:0]   chk_idx_r;
  logic               chk_vld_r;
  sst_entry_t         rd_r;

  logic [SLOT_COUNT-1:0] used_r, used_nxt;
  sst_entry_t            mem [SLOT_COUNT];

  logic               out_strobe_r;
  logic [STAT_W-1:0]  out_status_r, out_status_nxt;
  logic [OIDX_W-1:0]  out_idx_r, out_idx_nxt;
  logic [PERM_W-1:0]  out_perm_r, out_perm_nxt;

  logic issue, cur_used, own_eq, page_eq, hit, hit_v, found, mem_we;

  assign issue    = (addr_r < CNT_W'(SLOT_COUNT));
  assign cur_used = used_r[chk_idx_r];
  assign own_eq   = (rd_r.owner == owner_r);
  assign page_eq  = (rd_r.page == page_r);

  always_comb begin
    case (cmd_r)
      CMD_ALLOC:   hit = !cur_used;
      CMD_TAKE:    hit = cur_used && own_eq && page_eq;
      CMD_RELEASE: hit = cur_used && own_eq;
      default:     hit = 1'b0;
    endcase
  end

  assign hit_v     = chk_vld_r && hit;
  assign found     = hit_v && (cmd_r != CMD_RELEASE);
  assign sts.found = found;
  assign sts.last  = chk_vld_r && (chk_idx_r == IDX_W'(SLOT_COUNT - 1));
  assign mem_we    = ctl.step && hit_v && (cmd_r == CMD_ALLOC);
  assign addr_nxt  = addr_r + CNT_W'(1);

  always_comb begin
    used_nxt = used_r;
    if (ctl.step && hit_v) begin
      used_nxt[chk_idx_r] = (cmd_r == CMD_ALLOC);
    end
  end

  always_comb begin
    out_status_nxt = ST_DONE;
    out_idx_nxt    = '0;
    out_perm_nxt   = '0;
    if (found) begin
      out_idx_nxt = to_out_idx(chk_idx_r);
      if (cmd_r == CMD_TAKE) begin
        out_perm_nxt = rd_r.perm;
      end
    end else if (cmd_r == CMD_ALLOC) begin
      out_status_nxt = ST_FULL;
    end else if (cmd_r == CMD_TAKE) begin
      out_status_nxt = ST_MISSING;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r       <= '0;
      chk_vld_r    <= 1'b0;
      out_strobe_r <= 1'b0;
      addr_r       <= '0;
    end else begin
      used_r       <= used_nxt;
      chk_vld_r    <= ctl.step && issue;
      out_strobe_r <= ctl.finish;
      if (ctl.load) begin
        addr_r <= '0;
      end else if (ctl.step && issue) begin
        addr_r <= addr_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      cmd_r   <= in_command;
      owner_r <= in_owner_id;
      page_r  <= in_page_number;
      perm_r  <= in_permission_bits;
    end
    if (ctl.step) begin
      chk_idx_r <= addr_r[IDX_W-1:0];
    end
    if (ctl.finish) begin
      out_status_r <= out_status_nxt;
      out_idx_r    <= out_idx_nxt;
      out_perm_r   <= out_perm_nxt;
    end
  end

  // Slot memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[chk_idx_r] <= '{owner: owner_r, page: page_r, perm: perm_r};
    end
    if (ctl.step && issue) begin
      rd_r <= mem[addr_r[IDX_W-1:0]];
    end
  end

  assign out_strobe            = out_strobe_r;
  assign out_status            = out_status_r;
  assign out_slot_index        = out_idx_r;
  assign out_saved_permissions = out_perm_r;

  a_alloc_marks: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl.step && found && cmd_r == CMD_ALLOC) |=> used_r[$past(chk_idx_r)])
    else $error("allocated slot not marked used");

  a_take_frees: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl.step && found && cmd_r == CMD_TAKE) |=> !used_r[$past(chk_idx_r)])
    else $error("taken slot still marked used");

  a_full_means_full: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe_r && out_status_r == ST_FULL) |-> (&used_r))
    else $error("table-full reported with a free slot");

endmodule

/* rtl/swap_slot_table.sv */
// Channel  | Ports                                   | Handshake
// ---------+-----------------------------------------+-------------------------------
// request  | in_command, in_owner_id, in_page_number,| taken when start high and busy
//          | in_permission_bits                      | low at a rising edge
// result   | out_status, out_slot_index,             | out_strobe high for one cycle;
//          | out_saved_permissions                   | cannot be held off
//
// One request is handled at a time. The slot table is scanned one slot per cycle
// through the single read port of the slot memory. Each slot is first read into
// a register and then tested; the result registers and the strobe are loaded at
// the edge that ends the test of the slot the request settles on. A request that
// scans the whole table (table full, no match, release, unused code) raises the
// strobe after the test of the final slot. busy falls together with the result
// strobe, so the next request can be taken in the cycle the result is shown.
// Reset is synchronous and active low; it marks every slot free at once and
// needs no clearing pass. The receiver cannot stall, so results never wait.
module swap_slot_table
  import sst_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [CMD_W-1:0]   in_command,
  input  logic [OWNER_W-1:0] in_owner_id,
  input  logic [PAGE_W-1:0]  in_page_number,
  input  logic [PERM_W-1:0]  in_permission_bits,
  output logic               out_strobe,
  output logic [STAT_W-1:0]  out_status,
  output logic [OIDX_W-1:0]  out_slot_index,
  output logic [PERM_W-1:0]  out_saved_permissions
);

  // Command and status between the sequencer and the table datapath.
  sst_ctl_t ctl;
  sst_sts_t sts;

  // The sequencer runs the scan and decides when it ends: on the first
  // suitable slot for allocate or take, or after the final slot otherwise.
  sst_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .sts   (sts),
    .busy  (busy),
    .ctl   (ctl)
  );

  // The datapath holds the used marks, the slot memory, the request and the
  // result registers.
  sst_data u_data (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .ctl                   (ctl),
    .in_command            (in_command),
    .in_owner_id           (in_owner_id),
    .in_page_number        (in_page_number),
    .in_permission_bits    (in_permission_bits),
    .sts                   (sts),
    .out_strobe            (out_strobe),
    .out_status            (out_status),
    .out_slot_index        (out_slot_index),
    .out_saved_permissions (out_saved_permissions)
  );

endmodule
